/* src/character_stack_with_rotate_top_assert.svh */
// ----------------------------------------------------------------------------
// Character stack assertion macros
// Shorthand for the concurrent checks of the character stack top level.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_STACK_WITH_ROTATE_TOP_ASSERT_SVH
`define CHARACTER_STACK_WITH_ROTATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cstk_pkg.sv */
// ----------------------------------------------------------------------------
// Character stack package
// Command codes, status codes and the operation broadcast to the cell row.
// ----------------------------------------------------------------------------
package cstk_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;

  localparam logic [2:0] ACT_PUSH     = 3'd0;
  localparam logic [2:0] ACT_POP      = 3'd1;
  localparam logic [2:0] ACT_PEEK     = 3'd2;
  localparam logic [2:0] ACT_DUP      = 3'd3;
  localparam logic [2:0] ACT_DUMP     = 3'd4;
  localparam logic [2:0] ACT_ROT_UP   = 3'd5;
  localparam logic [2:0] ACT_ROT_DOWN = 3'd6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_DOWN,
    OP_SHIFT_UP,
    OP_ROT_UP,
    OP_ROT_DOWN
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] count;
  } cell_op_t;

endpackage

/* src/cstk_cell.sv */
// ----------------------------------------------------------------------------
// Character stack cell
// Holds the byte at one depth of the stack and moves it with its neighbors.
// ----------------------------------------------------------------------------
module cstk_cell import cstk_pkg::*; #(
  parameter int POS = 1
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] above,
  input  logic [DATA_W-1:0] below,
  input  logic [DATA_W-1:0] top,
  input  logic [DATA_W-1:0] pick,
  output logic [DATA_W-1:0] data
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (op.mode)
      OP_HOLD:       data_next = data;
      OP_SHIFT_DOWN: data_next = above;
      OP_SHIFT_UP:   data_next = below;
      OP_ROT_UP: begin
        if (POS_C < op.count) begin
          data_next = below;
        end else if (POS_C == op.count) begin
          data_next = top;
        end
      end
      OP_ROT_DOWN: begin
        if (POS_C == ONE_C) begin
          data_next = pick;
        end else if (POS_C <= op.count) begin
          data_next = above;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* src/character_stack_with_rotate_top.sv */
// ----------------------------------------------------------------------------
// Character stack with rotate
// Bounded byte stack with push, pop, peek, duplicate, dump and rotates.
// ----------------------------------------------------------------------------
// Commands arrive on a valid/ready channel (action, push_byte, rotate_count)
// and results leave on a valid/ready channel (status, out_byte, last).
// The stack limit is written through the APB-style port at address 0.
// The stack is a row of cells, the top of the stack in the first cell, so
// every command but a dump, rotates included, finishes in the cycle of its transfer.
// A command that gives one result registers it in the output register at its
// transfer. A dump of n entries first enters its dump state and then, while
// the receiver takes them, registers one result per cycle, n in all, by
// rotating the whole stack one place per result; the stack is back in its
// order after the last one, and then the next command is taken.
// Without stalls the block takes one command per cycle, and a dump
// holds the command channel until its last result is registered.
// When the receiver stalls, the result holds in the output register and no
// new command is taken until it is gone.
// Reset empties the stack and sets the limit to 32; cell contents are kept.
// ----------------------------------------------------------------------------
`include "character_stack_with_rotate_top_assert.svh"

module character_stack_with_rotate_top import cstk_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  push_byte,
  input  logic [5:0]  rotate_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  out_byte,
  output logic        last
);

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t            state;
  logic [5:0]        stack_limit;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     dump_left;
  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  logic [DATA_W-1:0] top_in;
  logic [DATA_W-1:0] pick;
  cell_op_t          op;
  logic              in_fire;
  logic              can_emit;
  logic              dump_emit;
  logic              result_load;
  logic              cfg_write;
  logic [CNT_W-1:0]  fill_ext;
  logic [CNT_W-1:0]  limit_ext;
  logic [CNT_W-1:0]  n_ext;
  logic              is_empty;
  logic              is_full;
  logic              rot_ok;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {26'd0, stack_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= 6'd32;
    end else if (cfg_write) begin
      stack_limit <= pwdata[5:0];
    end
  end

  assign can_emit  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && can_emit;
  assign in_fire   = in_valid && in_ready;
  assign dump_emit = (state == ST_DUMP) && can_emit;

  assign fill_ext  = CNT_W'(fill);
  assign limit_ext = CNT_W'(stack_limit);
  assign n_ext     = CNT_W'(rotate_count);
  assign is_empty  = (fill_ext == '0);
  assign is_full   = (fill_ext >= limit_ext) || (fill_ext >= DEPTH_C);
  assign rot_ok    = (n_ext != '0) && (n_ext <= fill_ext);

  always_comb begin
    result_load = dump_emit;
    if (in_fire) begin
      case (action)
        ACT_PUSH: result_load = is_full;
        ACT_POP:  result_load = is_empty;
        ACT_PEEK: result_load = 1'b1;
        ACT_DUP:  result_load = is_empty || is_full;
        ACT_DUMP: result_load = is_empty;
        default:  result_load = 1'b0;
      endcase
    end
  end

  always_comb begin
    op.mode  = OP_HOLD;
    op.count = n_ext;
    if (dump_emit) begin
      op.mode  = OP_ROT_UP;
      op.count = fill_ext;
    end else if (in_fire) begin
      case (action)
        ACT_PUSH:     if (!is_full) op.mode = OP_SHIFT_DOWN;
        ACT_POP:      if (!is_empty) op.mode = OP_SHIFT_UP;
        ACT_DUP:      if (!is_empty && !is_full) op.mode = OP_SHIFT_DOWN;
        ACT_ROT_UP:   if (rot_ok) op.mode = OP_ROT_UP;
        ACT_ROT_DOWN: if (rot_ok) op.mode = OP_ROT_DOWN;
        default:      op.mode = OP_HOLD;
      endcase
    end
  end

  assign top_in = (action == ACT_PUSH) ? push_byte : cell_q[0];

  always_comb begin
    pick = cell_q[0];
    for (int j = 0; j < STACK_DEPTH; j++) begin
      if (n_ext == CNT_W'(j + 1)) begin
        pick = cell_q[j];
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    if (g == 0) begin : g_first
      assign above = top_in;
    end else begin : g_inner_above
      assign above = cell_q[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_inner_below
      assign below = cell_q[g+1];
    end
    cstk_cell #(
      .POS (g + 1)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .above (above),
      .below (below),
      .top   (cell_q[0]),
      .pick  (pick),
      .data  (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      dump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (action)
              ACT_PUSH: begin
                if (is_full) begin
                  status    <= STATUS_FULL;
                  out_byte  <= '0;
                  last      <= 1'b1;
                end else begin
                  fill <= fill + FW'(1);
                end
              end
              ACT_POP: begin
                if (is_empty) begin
                  status    <= STATUS_EMPTY;
                  out_byte  <= '0;
                  last      <= 1'b1;
                end else begin
                  fill <= fill - FW'(1);
                end
              end
              ACT_PEEK: begin
                status    <= is_empty ? STATUS_EMPTY : STATUS_OK;
                out_byte  <= is_empty ? '0 : cell_q[0];
                last      <= 1'b1;
              end
              ACT_DUP: begin
                if (is_empty || is_full) begin
                  status    <= is_empty ? STATUS_EMPTY : STATUS_FULL;
                  out_byte  <= '0;
                  last      <= 1'b1;
                end else begin
                  fill <= fill + FW'(1);
                end
              end
              ACT_DUMP: begin
                if (is_empty) begin
                  status    <= STATUS_EMPTY;
                  out_byte  <= '0;
                  last      <= 1'b1;
                end else begin
                  state     <= ST_DUMP;
                  dump_left <= fill;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DUMP: begin
          if (dump_emit) begin
            status    <= STATUS_OK;
            out_byte  <= cell_q[0];
            last      <= (dump_left == FW'(1));
            dump_left <= dump_left - FW'(1);
            if (dump_left == FW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CSTK_ASSERT_SAME(a_fill_bound, 1'b1, fill_ext <= DEPTH_C, "fill above depth")
  `CSTK_ASSERT_SAME(a_dump_blocks_input, state == ST_DUMP, !in_ready,
    "command taken during dump")
  `CSTK_ASSERT_NEXT(a_push_grows, in_fire && action == ACT_PUSH && !is_full,
    fill == $past(fill) + FW'(1), "push did not grow the stack")
  `CSTK_ASSERT_NEXT(a_dump_ends, dump_emit && dump_left == FW'(1),
    state == ST_IDLE && out_valid && last, "dump did not end on its last entry")

endmodule

/* tb/tb_character_stack_with_rotate_top.sv */
// ----------------------------------------------------------------------------
// Character stack with rotate testbench
// Sends stack commands and checks every result against a predictor.
// ----------------------------------------------------------------------------
// A directed table covers the empty and full reports, the rotate ranges, an
// unused command code and limits of zero, below the fill and above the
// depth. Random commands follow in six segments with different limits,
// mostly filling the stack and then draining it. The predictor keeps its own
// copy of the stack and of the limit. Both channels idle at random, then
// the roles swap, then neither idles.
// ----------------------------------------------------------------------------
module tb_character_stack_with_rotate_top;
  import cstk_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS = 80;
  localparam int GROW_ITEMS = 55;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [2:0] ADDR_STACK_LIMIT = 3'd0;

  typedef struct packed {
    logic [1:0] stat;
    logic [7:0] value;
    logic       mark;
  } reply_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] act;
    logic [7:0] data;
    logic [5:0] count;
    logic       typed;
    reply_t     reply;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [7:0]  push_byte;
  logic [5:0]  rotate_count;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic        last;

  logic [7:0] stack_mem [STACK_DEPTH];
  int         stack_fill;
  logic [5:0] cfg_limit;

  reply_t   awaited_replies [$];
  reply_t   step_replies [$];
  dir_row_t directed_rows [$];

  int send_gap_pct;
  int recv_gap_pct;
  int n_errors;
  int n_cmds;
  int n_checked;
  int n_dumps;
  int n_dump_results;
  int deepest_fill;
  int stall_cycles;

  int         grow_mix [7];
  int         drain_mix [7];
  logic [2:0] mix_order [7];
  int         seg_limit [6];

  character_stack_with_rotate_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .push_byte   (push_byte),
    .rotate_count(rotate_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_byte    (out_byte),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic reply_t mk_reply(input logic [1:0] stat, input logic [7:0] value,
                                      input logic mark);
    reply_t r;
    r.stat = stat;
    r.value = value;
    r.mark = mark;
    return r;
  endfunction

  function automatic dir_row_t cmd_row(input logic [2:0] act, input logic [7:0] data,
                                       input logic [5:0] count);
    dir_row_t r;
    r.kind = ROW_CMD;
    r.act = act;
    r.data = data;
    r.count = count;
    r.typed = 1'b0;
    r.reply = mk_reply(STATUS_OK, 8'h00, 1'b0);
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [2:0] act, input logic [7:0] data,
                                         input logic [5:0] count, input reply_t reply);
    dir_row_t r;
    r = cmd_row(act, data, count);
    r.typed = 1'b1;
    r.reply = reply;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [5:0] lim);
    dir_row_t r;
    r = cmd_row(ACT_UNUSED, 8'h00, lim);
    r.kind = ROW_CFG;
    return r;
  endfunction

  // Applies one command to the local stack and lists the results it gives.
  function automatic void predict_stack(input logic [2:0] act, input logic [7:0] data,
                                        input logic [5:0] count);
    int         lim;
    int         n;
    logic [7:0] held;
    step_replies.delete();
    lim = (cfg_limit > STACK_DEPTH) ? STACK_DEPTH : int'(cfg_limit);
    n = int'(count);
    case (act)
      ACT_PUSH: begin
        if (stack_fill >= lim) begin
          step_replies.push_back(mk_reply(STATUS_FULL, 8'h00, 1'b1));
        end else begin
          stack_mem[stack_fill] = data;
          stack_fill++;
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) step_replies.push_back(mk_reply(STATUS_EMPTY, 8'h00, 1'b1));
        else stack_fill--;
      end
      ACT_PEEK: begin
        if (stack_fill == 0) step_replies.push_back(mk_reply(STATUS_EMPTY, 8'h00, 1'b1));
        else step_replies.push_back(mk_reply(STATUS_OK, stack_mem[stack_fill-1], 1'b1));
      end
      ACT_DUP: begin
        if (stack_fill == 0) begin
          step_replies.push_back(mk_reply(STATUS_EMPTY, 8'h00, 1'b1));
        end else if (stack_fill >= lim) begin
          step_replies.push_back(mk_reply(STATUS_FULL, 8'h00, 1'b1));
        end else begin
          stack_mem[stack_fill] = stack_mem[stack_fill-1];
          stack_fill++;
        end
      end
      ACT_DUMP: begin
        if (stack_fill == 0) begin
          step_replies.push_back(mk_reply(STATUS_EMPTY, 8'h00, 1'b1));
        end else begin
          for (int i = stack_fill; i > 0; i--) begin
            step_replies.push_back(mk_reply(STATUS_OK, stack_mem[i-1], i == 1));
          end
        end
      end
      ACT_ROT_UP: begin
        if (n >= 1 && n <= stack_fill) begin
          held = stack_mem[stack_fill-1];
          for (int i = stack_fill - 1; i > stack_fill - n; i--) stack_mem[i] = stack_mem[i-1];
          stack_mem[stack_fill-n] = held;
        end
      end
      ACT_ROT_DOWN: begin
        if (n >= 1 && n <= stack_fill) begin
          held = stack_mem[stack_fill-n];
          for (int i = stack_fill - n; i + 1 < stack_fill; i++) stack_mem[i] = stack_mem[i+1];
          stack_mem[stack_fill-1] = held;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_cmd(input logic [2:0] act, input logic [7:0] data,
                          input logic [5:0] count, input logic typed, input reply_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    push_byte <= data;
    rotate_count <= count;
    do @(posedge clk); while (!in_ready);
    predict_stack(act, data, count);
    if (typed) begin
      awaited_replies.push_back(want);
    end else begin
      foreach (step_replies[k]) awaited_replies.push_back(step_replies[k]);
    end
    n_cmds++;
    if (act == ACT_DUMP && stack_fill > 0) begin
      n_dumps++;
      n_dump_results += stack_fill;
    end
    if (stack_fill > deepest_fill) deepest_fill = stack_fill;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] value);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_STACK_LIMIT;
    pwdata <= {26'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[5:0] !== value) report_mismatch("stack_limit readback", {2'b00, got[5:0]},
                                            {2'b00, value});
    cfg_limit = value;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected result, out_byte", out_byte, 8'h00);
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.stat) report_mismatch("status", {6'd0, status}, {6'd0, want.stat});
        if (out_byte !== want.value) report_mismatch("out_byte", out_byte, want.value);
        if (last !== want.mark) report_mismatch("last", {7'd0, last}, {7'd0, want.mark});
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         sent;
    int         r;
    logic [2:0] act;
    logic [5:0] count;
    reply_t     none;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_STACK_LIMIT;
    pwdata = 32'd0;
    in_valid = 1'b0;
    action = ACT_PUSH;
    push_byte = 8'h00;
    rotate_count = 6'd0;
    out_ready = 1'b0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    n_errors = 0;
    n_cmds = 0;
    n_checked = 0;
    n_dumps = 0;
    n_dump_results = 0;
    deepest_fill = 0;
    stack_fill = 0;
    cfg_limit = 6'd32;
    none = mk_reply(STATUS_OK, 8'h00, 1'b0);
    grow_mix = '{40, 52, 60, 68, 73, 85, 97};
    drain_mix = '{12, 17, 55, 63, 70, 80, 90};
    mix_order = '{ACT_PUSH, ACT_DUP, ACT_POP, ACT_PEEK, ACT_DUMP, ACT_ROT_UP, ACT_ROT_DOWN};
    seg_limit = '{32, 1, 9, 0, 63, 20};

    directed_rows.push_back(typed_row(ACT_POP, 8'h00, 6'd0,
                                      mk_reply(STATUS_EMPTY, 8'h00, 1'b1)));
    directed_rows.push_back(typed_row(ACT_PEEK, 8'h00, 6'd0,
                                      mk_reply(STATUS_EMPTY, 8'h00, 1'b1)));
    directed_rows.push_back(typed_row(ACT_DUP, 8'h00, 6'd0,
                                      mk_reply(STATUS_EMPTY, 8'h00, 1'b1)));
    directed_rows.push_back(typed_row(ACT_DUMP, 8'h00, 6'd0,
                                      mk_reply(STATUS_EMPTY, 8'h00, 1'b1)));
    directed_rows.push_back(cmd_row(ACT_ROT_UP, 8'h00, 6'd1));
    directed_rows.push_back(cmd_row(ACT_PUSH, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_PUSH, 8'hFF, 6'd63));
    directed_rows.push_back(cmd_row(ACT_PUSH, 8'hA5, 6'd0));
    directed_rows.push_back(typed_row(ACT_PEEK, 8'h00, 6'd0,
                                      mk_reply(STATUS_OK, 8'hA5, 1'b1)));
    directed_rows.push_back(cmd_row(ACT_DUP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_ROT_UP, 8'h00, 6'd3));
    directed_rows.push_back(cmd_row(ACT_ROT_DOWN, 8'h00, 6'd4));
    directed_rows.push_back(cmd_row(ACT_ROT_UP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_ROT_DOWN, 8'h00, 6'd5));
    directed_rows.push_back(cmd_row(ACT_ROT_UP, 8'h00, 6'd63));
    directed_rows.push_back(cmd_row(ACT_DUMP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_UNUSED, 8'hFF, 6'd63));
    directed_rows.push_back(cmd_row(ACT_POP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_PEEK, 8'h00, 6'd0));
    directed_rows.push_back(cfg_row(6'd2));
    directed_rows.push_back(typed_row(ACT_PUSH, 8'h5A, 6'd0,
                                      mk_reply(STATUS_FULL, 8'h00, 1'b1)));
    directed_rows.push_back(typed_row(ACT_DUP, 8'h00, 6'd0,
                                      mk_reply(STATUS_FULL, 8'h00, 1'b1)));
    directed_rows.push_back(cmd_row(ACT_POP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_POP, 8'h00, 6'd0));
    directed_rows.push_back(cmd_row(ACT_PUSH, 8'h3C, 6'd0));
    directed_rows.push_back(typed_row(ACT_PUSH, 8'h81, 6'd0,
                                      mk_reply(STATUS_FULL, 8'h00, 1'b1)));
    directed_rows.push_back(cfg_row(6'd0));
    directed_rows.push_back(typed_row(ACT_DUP, 8'h00, 6'd0,
                                      mk_reply(STATUS_FULL, 8'h00, 1'b1)));
    directed_rows.push_back(cfg_row(6'd63));
    directed_rows.push_back(cmd_row(ACT_DUMP, 8'h00, 6'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 29;
    recv_gap_pct = 52;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        wait_drained();
        write_limit(directed_rows[k].count);
      end else begin
        send_cmd(directed_rows[k].act, directed_rows[k].data, directed_rows[k].count,
                 directed_rows[k].typed, directed_rows[k].reply);
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      write_limit(seg_limit[seg][5:0]);
      send_gap_pct = (seg < 2) ? 29 : (seg < 4) ? 52 : 0;
      recv_gap_pct = (seg < 2) ? 52 : (seg < 4) ? 29 : 0;
      sent = 0;
      while (sent < SEG_ITEMS) begin
        r = $urandom_range(99);
        act = ACT_UNUSED;
        for (int j = 6; j >= 0; j--) begin
          if (r < ((sent < GROW_ITEMS) ? grow_mix[j] : drain_mix[j])) act = mix_order[j];
        end
        if (stack_fill == 0) begin
          count = 6'($urandom_range(63));
        end else begin
          r = $urandom_range(9);
          if (r < 8) count = 6'($urandom_range(stack_fill, 1));
          else if (r == 8) count = 6'd0;
          else count = 6'($urandom_range(63, stack_fill + 1));
        end
        if (act != ACT_UNUSED) sent++;
        send_cmd(act, 8'($urandom_range(255)), count, 1'b0, none);
        if (seg == 2 && sent == SEG_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d commands and checked %0d results, %0d of them from %0d dumps.",
             n_cmds, n_checked, n_dump_results, n_dumps);
    $display("Limits 0 to 63 were used, the deepest fill was %0d, with idling on both sides.",
             deepest_fill);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/cstk_pkg.sv
src/cstk_cell.sv
src/character_stack_with_rotate_top.sv
tb/tb_character_stack_with_rotate_top.sv
